FILE: sv/iiea_pkg.sv
package iiea_pkg;

  localparam int CAPACITY   = 64;
  localparam int WORD_WIDTH = 64;

  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int VALUE_W = 64;
  localparam int LEN_W   = 7;
  localparam int ST_W    = 2;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [OP_W-1:0]       op_t;
  typedef logic [ST_W-1:0]       status_t;
  typedef logic [WORD_WIDTH-1:0] entry_t;

  localparam op_t OP_INSERT = 3'd0;
  localparam op_t OP_ERASE  = 3'd1;
  localparam op_t OP_READ   = 3'd2;
  localparam op_t OP_WRITE  = 3'd3;
  localparam op_t OP_PUSH   = 3'd4;
  localparam op_t OP_POP    = 3'd5;
  localparam op_t OP_REINIT = 3'd6;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

FILE: sv/iiea_if.sv
interface iiea_in_if import iiea_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 operation;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, operation, position, value, input ready);
  modport sink (input valid, operation, position, value, output ready);
endinterface

interface iiea_out_if import iiea_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  read_value;
  logic [LEN_W-1:0]    length;
  status_t             status;
  logic                is_empty;

  modport source (output valid, read_value, length, status, is_empty, input ready);
  modport sink (input valid, read_value, length, status, is_empty, output ready);
endinterface

FILE: sv/indexed_insert_erase_array_unit.sv
// Ordered array of CAPACITY entries with a current length, supporting insert, erase, read,
// write, push, pop and re-initialise. Every accepted word is registered, then processed
// combinationally: all entries shift in parallel from their neighbors, so the unit takes one
// word per cycle unless the result is stalled, and registers its result in the result register.
// Throughput is set by the per-entry shift network between the input register and the result
// register; a stalled result holds the pipeline, while the input register keeps taking a word
// whenever it can move on. Re-initialise zeroes every entry and sets the length to the position.
module indexed_insert_erase_array_unit import iiea_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  iiea_in_if.sink    in_chan,
  iiea_out_if.source out_chan
);

  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [POS_W-1:0]   s1_pos_r;
  entry_t             s1_value_r;

  entry_t             entries_r   [CAPACITY];
  entry_t             entries_nxt [CAPACITY];
  entry_t             prev_entry  [CAPACITY];
  entry_t             next_entry  [CAPACITY];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_read_value_r;
  status_t            out_status_r;

  logic               advance;
  logic [CMP_W-1:0]   pos_c;
  logic [CMP_W-1:0]   cnt_c;
  logic [CMP_W-1:0]   eff_pos;
  logic               do_ins;
  logic               do_era;
  logic               do_wr;
  logic               do_clr;
  status_t            st;
  logic [VALUE_W-1:0] rd;

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
    if (g == 0) begin : g_first
      assign prev_entry[g] = '0;
    end else begin : g_prev
      assign prev_entry[g] = entries_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_entry[g] = '0;
    end else begin : g_next
      assign next_entry[g] = entries_r[g+1];
    end
  end

  always_comb begin
    pos_c     = CMP_W'(s1_pos_r);
    cnt_c     = CMP_W'(count_r);
    eff_pos   = pos_c;
    do_ins    = 1'b0;
    do_era    = 1'b0;
    do_wr     = 1'b0;
    do_clr    = 1'b0;
    st        = ST_OK;
    rd        = '0;
    count_nxt = count_r;
    unique case (s1_op_r)
      OP_INSERT: begin
        if (pos_c > cnt_c) begin
          st = ST_RANGE;
        end else if (cnt_c >= CMP_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (pos_c >= cnt_c) begin
          st = ST_RANGE;
        end else begin
          do_era    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_c >= cnt_c) begin
          st = ST_RANGE;
        end else begin
          rd = VALUE_W'(entries_r[pos_c[IDX_W-1:0]]);
        end
      end
      OP_WRITE: begin
        if (pos_c >= cnt_c) begin
          st = ST_RANGE;
        end else begin
          do_wr = 1'b1;
        end
      end
      OP_PUSH: begin
        eff_pos = cnt_c;
        if (cnt_c >= CMP_W'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        eff_pos = cnt_c - CMP_W'(1);
        if (count_r == '0) begin
          st = ST_RANGE;
        end else begin
          do_era    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_REINIT: begin
        if (pos_c > CMP_W'(CAPACITY)) begin
          st = ST_RANGE;
        end else begin
          do_clr    = 1'b1;
          count_nxt = CNT_W'(pos_c);
        end
      end
      default: begin
      end
    endcase

    for (int k = 0; k < CAPACITY; k++) begin
      entries_nxt[k] = entries_r[k];
      if (do_clr) begin
        entries_nxt[k] = '0;
      end else if (do_ins) begin
        if (CMP_W'(k) == eff_pos) begin
          entries_nxt[k] = s1_value_r;
        end else if (CMP_W'(k) > eff_pos && CMP_W'(k) <= cnt_c) begin
          entries_nxt[k] = prev_entry[k];
        end
      end else if (do_era) begin
        if (CMP_W'(k) >= eff_pos && CMP_W'(k) + CMP_W'(1) < cnt_c) begin
          entries_nxt[k] = next_entry[k];
        end
      end else if (do_wr) begin
        if (CMP_W'(k) == eff_pos) begin
          entries_nxt[k] = s1_value_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_op_r    <= in_chan.operation;
      s1_pos_r   <= in_chan.position;
      s1_value_r <= in_chan.value[WORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < CAPACITY; k++) begin
        entries_r[k] <= '0;
      end
    end else if (advance) begin
      count_r <= count_nxt;
      for (int k = 0; k < CAPACITY; k++) begin
        entries_r[k] <= entries_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_value_r <= rd;
      out_status_r     <= st;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_value = out_read_value_r;
  assign out_chan.length     = LEN_W'(count_r);
  assign out_chan.status     = out_status_r;
  assign out_chan.is_empty   = (count_r == '0);

endmodule
